>>> hdl/pba_pkg.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared constants, status codes and the control program of the sequencer.
// ----------------------------------------------------------------------------
package pba_pkg;

	// Geometry of the free bitmap. The page field is nine bits wide, so the
	// page count and the word layout are fixed.
	localparam int PAGE_COUNT = 512;
	localparam int WORD_BITS  = 32;
	localparam int WORD_COUNT = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int PAGE_W     = 9;
	localparam int WADDR_W    = 4;
	localparam int BIT_W      = 5;
	localparam int RES_W      = 10;
	localparam int LAST_BITS  = PAGE_COUNT - WORD_BITS * (WORD_COUNT - 1);
	localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORD_COUNT - 1);
	localparam logic [WORD_BITS-1:0] ALL_FREE = 32'hFFFF_FFFF;
	localparam logic [WORD_BITS-1:0] LAST_MASK =
		(LAST_BITS == WORD_BITS) ? ALL_FREE : WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_FREE      = 2'd1,
		ST_BAD_PAGE     = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	// Datapath operation selected by a control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LATCH,
		OP_AINIT,
		OP_ASCAN,
		OP_FREE,
		OP_EMIT
	} op_t;

	// Jump condition of a control word.
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_NO_REQ,
		C_ACT_FREE,
		C_RES_OVER,
		C_SCAN_MORE,
		C_OUT_BUSY
	} cond_t;

	localparam int STEP_W = 3;

	// One control word: operation, jump condition, jump target, and a flag
	// that sends the sequencer back to step zero when the jump is not taken.
	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
		logic              last;
	} uword_t;

	// Step numbers of the control program.
	localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_AINIT  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_ASCAN  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_FREE   = 3'd5;

	// Control program held in a read-only table.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		unique case (step)
			STEP_WAIT:   w = '{op: OP_LATCH, cond: C_NO_REQ,    target: STEP_WAIT,  last: 1'b0};
			STEP_DECODE: w = '{op: OP_NOP,   cond: C_ACT_FREE,  target: STEP_FREE,  last: 1'b0};
			STEP_AINIT:  w = '{op: OP_AINIT, cond: C_RES_OVER,  target: STEP_EMIT,  last: 1'b0};
			STEP_ASCAN:  w = '{op: OP_ASCAN, cond: C_SCAN_MORE, target: STEP_ASCAN, last: 1'b0};
			STEP_EMIT:   w = '{op: OP_EMIT,  cond: C_OUT_BUSY,  target: STEP_EMIT,  last: 1'b1};
			STEP_FREE:   w = '{op: OP_FREE,  cond: C_ALWAYS,    target: STEP_EMIT,  last: 1'b0};
			default:     w = '{op: OP_NOP,   cond: C_ALWAYS,    target: STEP_WAIT,  last: 1'b0};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/page_bitmap_allocator.sv
// A free reads and writes back the bitmap word of its page. An allocate scans
// one bitmap word per cycle from the word that holds reserved_pages, 0 to 16
// words in all (0 when the reservation covers all memory). One request is in
// work at a time; a finished result waits in the output register. Reset frees
// every page, clears reserved_pages.
// ----------------------------------------------------------------------------
// Page bitmap allocator
// Hands out and takes back physical pages kept in a free bitmap, driven by
// a small microcoded sequencer over a one-word read/modify/write datapath.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	// Configuration write channel.
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pba_pkg::RES_W-1:0]  reserved_pages,
	// Request channel.
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       action,
	input  logic [pba_pkg::PAGE_W-1:0] page,
	// Result channel.
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [pba_pkg::PAGE_W-1:0] granted_page,
	output logic [1:0]                 status
);

	logic [pba_pkg::STEP_W-1:0]    step_q;
	pba_pkg::uword_t               uw;
	logic [pba_pkg::RES_W-1:0]     res_q;
	logic                          act_q;
	logic [pba_pkg::PAGE_W-1:0]    page_q;
	logic [pba_pkg::WADDR_W-1:0]   wp_q;
	logic [pba_pkg::PAGE_W-1:0]    gp_q;
	pba_pkg::status_t              st_q;
	logic                          out_valid_q;
	logic [pba_pkg::PAGE_W-1:0]    out_page_q;
	pba_pkg::status_t              out_st_q;
	logic [pba_pkg::WORD_BITS-1:0] bits_q [pba_pkg::WORD_COUNT];

	logic [pba_pkg::WADDR_W-1:0]   rd_addr;
	logic [pba_pkg::WORD_BITS-1:0] rd_word;
	logic [pba_pkg::WORD_BITS-1:0] low_mask;
	logic [pba_pkg::WORD_BITS-1:0] cand;
	logic [pba_pkg::BIT_W-1:0]     idx;
	logic                          found;
	logic                          res_over;
	logic                          out_busy;
	logic                          page_bad;
	logic                          page_free;
	logic                          jump;

	// Current control word.
	assign uw = pba_pkg::ucode(step_q);

	// Handshake outputs.
	assign in_stall     = (uw.op != pba_pkg::OP_LATCH);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign granted_page = out_page_q;
	assign status       = out_st_q;
	assign out_busy     = out_valid_q && out_stall;

	// One bitmap word is read per cycle, from the scan pointer or the freed page.
	assign rd_addr = (uw.op == pba_pkg::OP_FREE) ? page_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]
		: wp_q;
	assign rd_word = bits_q[rd_addr];

	// Reservation at or beyond the page count leaves nothing to allocate.
	assign res_over = (res_q >= pba_pkg::RES_W'(pba_pkg::PAGE_COUNT));

	// Candidate pages in the scanned word: hide pages below the reservation
	// and pages past the end of memory.
	always_comb begin
		low_mask = pba_pkg::ALL_FREE;
		if (wp_q == res_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W]) begin
			low_mask = ~((pba_pkg::WORD_BITS'(1) << res_q[pba_pkg::BIT_W-1:0])
				- pba_pkg::WORD_BITS'(1));
		end
		cand = rd_word & low_mask
			& ((wp_q == pba_pkg::LAST_WORD) ? pba_pkg::LAST_MASK : pba_pkg::ALL_FREE);
	end

	// Lowest set bit of the candidate word.
	always_comb begin
		idx = '0;
		for (int i = pba_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = pba_pkg::BIT_W'(i);
			end
		end
	end
	assign found = |cand;

	// Checks for a free request.
	assign page_bad = ({1'b0, page_q} < res_q)
		|| ({1'b0, page_q} >= pba_pkg::RES_W'(pba_pkg::PAGE_COUNT));
	assign page_free = rd_word[page_q[pba_pkg::BIT_W-1:0]];

	// Jump condition of the current control word.
	always_comb begin
		unique case (uw.cond)
			pba_pkg::C_ALWAYS:    jump = 1'b1;
			pba_pkg::C_NO_REQ:    jump = !in_valid;
			pba_pkg::C_ACT_FREE:  jump = act_q;
			pba_pkg::C_RES_OVER:  jump = res_over;
			pba_pkg::C_SCAN_MORE: jump = !found && (wp_q != pba_pkg::LAST_WORD);
			pba_pkg::C_OUT_BUSY:  jump = out_busy;
			default:              jump = 1'b1;
		endcase
	end

	// Step counter of the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pba_pkg::STEP_WAIT;
		end else if (jump) begin
			step_q <= uw.target;
		end else if (uw.last) begin
			step_q <= pba_pkg::STEP_WAIT;
		end else begin
			step_q <= step_q + pba_pkg::STEP_W'(1);
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			res_q <= reserved_pages;
		end
	end

	// Free bitmap: read, modify and write back one word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < pba_pkg::WORD_COUNT; w++) begin
				bits_q[w] <= pba_pkg::ALL_FREE;
			end
		end else if (uw.op == pba_pkg::OP_ASCAN && found) begin
			bits_q[rd_addr][idx] <= 1'b0;
		end else if (uw.op == pba_pkg::OP_FREE && !page_bad && !page_free) begin
			bits_q[rd_addr][page_q[pba_pkg::BIT_W-1:0]] <= 1'b1;
		end
	end

	// Request fields, scan pointer and pending result.
	always_ff @(posedge clk) begin
		unique case (uw.op)
			pba_pkg::OP_LATCH: begin
				if (in_valid) begin
					act_q  <= action;
					page_q <= page;
				end
			end
			pba_pkg::OP_AINIT: begin
				wp_q <= res_q[pba_pkg::PAGE_W-1:pba_pkg::BIT_W];
				gp_q <= '0;
				st_q <= pba_pkg::ST_NO_FREE;
			end
			pba_pkg::OP_ASCAN: begin
				if (found) begin
					gp_q <= {wp_q, idx};
					st_q <= pba_pkg::ST_OK;
				end else if (wp_q != pba_pkg::LAST_WORD) begin
					wp_q <= wp_q + pba_pkg::WADDR_W'(1);
				end
			end
			pba_pkg::OP_FREE: begin
				gp_q <= '0;
				if (page_bad) begin
					st_q <= pba_pkg::ST_BAD_PAGE;
				end else if (page_free) begin
					st_q <= pba_pkg::ST_ALREADY_FREE;
				end else begin
					st_q <= pba_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: loaded by the emit step once the previous result is gone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (uw.op == pba_pkg::OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.op == pba_pkg::OP_EMIT && !out_busy) begin
			out_page_q <= gp_q;
			out_st_q   <= st_q;
		end
	end

endmodule

>>> hdl/pba_checker.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Port-level assertions on the request, result and handshake behavior.
// ----------------------------------------------------------------------------
module pba_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [pba_pkg::PAGE_W-1:0] granted_page,
	input logic [1:0]                 status
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_page) && $stable(status))
		else $error("stalled result changed");

	// A result with a failing status carries page number zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != pba_pkg::ST_OK) |-> (granted_page == '0))
		else $error("page number on a failed request");

	// After a request is taken the block works on it alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken while one is in work");

	// A result never appears in the cycle right after its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.granted_page (granted_page),
	.status       (status)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives allocate and free requests through the valid/stall channels and
// compares every result against a bitmap model kept in the bench. A short
// stimulus table covers the edge cases first. Random phases follow, each
// with its own reservation, and they mix fill, drain and malformed requests.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic ACT_ALLOC    = 1'b0;
	localparam logic ACT_FREE     = 1'b1;
	localparam int   RANDOM_ITEMS = 1100;
	localparam int   HOLD_AT      = 400;
	localparam int   HOLD_CYCLES  = 250;
	localparam int   DRAIN_CYCLES = 30;
	localparam int   PLAN_LEN     = 28;
	localparam int   REPORT_MAX   = 10;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One row of the stimulus table. For a configuration row, arg holds the
	// reservation. For a request row, arg holds the page.
	typedef struct {
		row_kind_t                  kind;
		logic                       act;
		logic [pba_pkg::RES_W-1:0]  arg;
		bit                         fixed;
		logic [pba_pkg::PAGE_W-1:0] exp_page;
		pba_pkg::status_t           exp_status;
	} row_t;

	typedef struct {
		logic [pba_pkg::PAGE_W-1:0] page;
		pba_pkg::status_t           status;
	} grant_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [pba_pkg::RES_W-1:0]  reserved_pages;
	logic                       in_valid;
	logic                       in_stall;
	logic                       action;
	logic [pba_pkg::PAGE_W-1:0] page;
	logic                       out_valid;
	logic                       out_stall;
	logic [pba_pkg::PAGE_W-1:0] granted_page;
	logic [1:0]                 status;

	// Bench copy of the free bitmap and the reservation register.
	logic [pba_pkg::WORD_BITS-1:0] free_map [pba_pkg::WORD_COUNT];
	logic [pba_pkg::RES_W-1:0]     os_reserve;
	grant_t                        pending_grants [$];
	row_t                          plan [PLAN_LEN];
	int                            fault_count;
	int                            req_count;
	int                            result_count;

	page_bitmap_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.reserved_pages (reserved_pages),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.action         (action),
		.page           (page),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.granted_page   (granted_page),
		.status         (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Applies one request to the bitmap model and returns its result.
	function automatic void compute_grant(input logic act,
			input logic [pba_pkg::PAGE_W-1:0] pg,
			output logic [pba_pkg::PAGE_W-1:0] gp, output pba_pkg::status_t st);
		int p;
		bit found;
		gp = '0;
		found = 1'b0;
		if (act == ACT_ALLOC) begin
			st = pba_pkg::ST_NO_FREE;
			for (p = int'(os_reserve); p < pba_pkg::PAGE_COUNT && !found; p++) begin
				if (free_map[p >> 5][p & 31]) begin
					free_map[p >> 5][p & 31] = 1'b0;
					gp = pba_pkg::PAGE_W'(p);
					st = pba_pkg::ST_OK;
					found = 1'b1;
				end
			end
		end else if (int'(pg) < int'(os_reserve) || int'(pg) >= pba_pkg::PAGE_COUNT) begin
			st = pba_pkg::ST_BAD_PAGE;
		end else if (free_map[pg >> 5][pg & 31]) begin
			st = pba_pkg::ST_ALREADY_FREE;
		end else begin
			free_map[pg >> 5][pg & 31] = 1'b1;
			st = pba_pkg::ST_OK;
		end
	endfunction

	// Finds a page in use at or above the reservation, searching from start.
	function automatic int find_used(input int start);
		int i;
		int p;
		for (i = 0; i < pba_pkg::PAGE_COUNT; i++) begin
			p = (start + i) % pba_pkg::PAGE_COUNT;
			if (p >= int'(os_reserve) && !free_map[p >> 5][p & 31])
				return p;
		end
		return -1;
	endfunction

	// Draws a reservation for a random phase. It mostly picks normal values and
	// sometimes a tight window or one at or past the end of memory.
	function automatic logic [pba_pkg::RES_W-1:0] pick_reserve();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 3)
			return '0;
		else if (roll < 6)
			return pba_pkg::RES_W'($urandom_range(0, pba_pkg::PAGE_COUNT - 1));
		else if (roll < 8)
			return pba_pkg::RES_W'($urandom_range(pba_pkg::PAGE_COUNT - 64,
				pba_pkg::PAGE_COUNT - 1));
		else if (roll < 9)
			return pba_pkg::RES_W'($urandom_range(pba_pkg::PAGE_COUNT, 1023));
		return pba_pkg::RES_W'(1023);
	endfunction

	function automatic int sender_gap();
		if ((req_count / 50) % 4 == 3)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	function automatic int receiver_gap();
		if ((result_count / 40) % 5 == 4)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// Offers one request and records its expected result once it is taken.
	task automatic issue_request(input logic act, input logic [pba_pkg::PAGE_W-1:0] pg,
			input bit fixed, input logic [pba_pkg::PAGE_W-1:0] fx_page,
			input pba_pkg::status_t fx_status);
		int gap;
		grant_t want;
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		page     <= pg;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		compute_grant(act, pg, want.page, want.status);
		if (fixed) begin
			want.page   = fx_page;
			want.status = fx_status;
		end
		pending_grants.push_back(want);
		req_count++;
	endtask

	// Writes the reservation once every outstanding result has come back.
	task automatic write_reserve(input logic [pba_pkg::RES_W-1:0] value);
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		cfg_valid      <= 1'b1;
		reserved_pages <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		os_reserve = value;
	endtask

	// Result side: random stall before each result, one long hold-off, and
	// an in-order check of every result.
	initial begin
		int wait_cycles;
		grant_t want;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			wait_cycles = (result_count == HOLD_AT) ? HOLD_CYCLES : receiver_gap();
			if (wait_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_grants.size() == 0) begin
				if (fault_count < REPORT_MAX)
					$display("unexpected result: page %0d status %0d", granted_page, status);
				fault_count++;
			end else begin
				want = pending_grants.pop_front();
				if (granted_page !== want.page || status !== want.status) begin
					if (fault_count < REPORT_MAX)
						$display("result %0d: expected page %0d status %0d, got page %0d status %0d",
							result_count, want.page, want.status, granted_page, status);
					fault_count++;
				end
			end
			result_count++;
		end
	end

	// Request side: stimulus table, then random phases, then drain.
	initial begin
		int i;
		int sent;
		int phase_len;
		int alloc_pct;
		int roll;
		int victim;
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		reserved_pages = '0;
		in_valid       = 1'b0;
		action         = ACT_ALLOC;
		page           = '0;
		out_stall      = 1'b0;
		fault_count    = 0;
		req_count      = 0;
		result_count   = 0;
		sent           = 0;
		os_reserve     = '0;
		for (i = 0; i < pba_pkg::WORD_COUNT; i++)
			free_map[i] = pba_pkg::ALL_FREE;

		plan = '{
			// Fresh bitmap with no reservation: lowest pages first, then a double free.
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd1,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd1,    1'b1, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd1,    1'b1, 9'd0,   pba_pkg::ST_ALREADY_FREE},
			'{ROW_REQ, ACT_FREE,  10'd511,  1'b1, 9'd0,   pba_pkg::ST_ALREADY_FREE},
			'{ROW_REQ, ACT_FREE,  10'd0,    1'b1, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd511,  1'b1, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b0, 9'd0,   pba_pkg::ST_OK},
			// Reservation covering all of memory.
			'{ROW_CFG, ACT_ALLOC, 10'd512,  1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd0,   pba_pkg::ST_NO_FREE},
			'{ROW_REQ, ACT_FREE,  10'd0,    1'b1, 9'd0,   pba_pkg::ST_BAD_PAGE},
			'{ROW_REQ, ACT_FREE,  10'd511,  1'b1, 9'd0,   pba_pkg::ST_BAD_PAGE},
			'{ROW_CFG, ACT_ALLOC, 10'd1023, 1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd0,   pba_pkg::ST_NO_FREE},
			'{ROW_REQ, ACT_FREE,  10'd511,  1'b1, 9'd0,   pba_pkg::ST_BAD_PAGE},
			// Only the top page is left to allocate.
			'{ROW_CFG, ACT_ALLOC, 10'd511,  1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd511, pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b1, 9'd0,   pba_pkg::ST_NO_FREE},
			'{ROW_REQ, ACT_FREE,  10'd511,  1'b1, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd510,  1'b1, 9'd0,   pba_pkg::ST_BAD_PAGE},
			// Reservation at the last page of a word, so the second scan crosses into the next word.
			'{ROW_CFG, ACT_ALLOC, 10'd31,   1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b0, 9'd0,   pba_pkg::ST_OK},
			// The reservation is lowered again. Pages taken earlier are still in use.
			'{ROW_CFG, ACT_ALLOC, 10'd0,    1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_ALLOC, 10'd0,    1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd1,    1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd31,   1'b0, 9'd0,   pba_pkg::ST_OK},
			'{ROW_REQ, ACT_FREE,  10'd32,   1'b0, 9'd0,   pba_pkg::ST_OK}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PLAN_LEN; i++) begin
			if (plan[i].kind == ROW_CFG)
				write_reserve(plan[i].arg);
			else
				issue_request(plan[i].act, plan[i].arg[pba_pkg::PAGE_W-1:0], plan[i].fixed,
					plan[i].exp_page, plan[i].exp_status);
		end

		// Each random phase picks its own reservation and its own fill or drain bias.
		while (sent < RANDOM_ITEMS) begin
			write_reserve(pick_reserve());
			phase_len = $urandom_range(60, 160);
			alloc_pct = $urandom_range(25, 90);
			for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					issue_request(ACT_FREE, pba_pkg::PAGE_W'($urandom), 1'b0, '0,
						pba_pkg::ST_OK);
				end else if ($urandom_range(0, 99) < alloc_pct) begin
					issue_request(ACT_ALLOC, pba_pkg::PAGE_W'($urandom), 1'b0, '0,
						pba_pkg::ST_OK);
				end else begin
					victim = find_used($urandom_range(0, pba_pkg::PAGE_COUNT - 1));
					if (victim < 0)
						issue_request(ACT_ALLOC, pba_pkg::PAGE_W'($urandom), 1'b0, '0,
							pba_pkg::ST_OK);
					else
						issue_request(ACT_FREE, pba_pkg::PAGE_W'(victim), 1'b0, '0,
							pba_pkg::ST_OK);
				end
				sent++;
			end
		end

		// Let the last results come back, then watch for anything extra.
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_grants.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> page_bitmap_allocator.f
hdl/pba_pkg.sv
hdl/page_bitmap_allocator.sv
hdl/pba_checker.sv
dv/testbench.sv
